FILE: hw/rtl/assert_macros.svh
// assertion macros used by the queue top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every rising clock edge outside reset
`define PSQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");

// expression must never be true outside reset
`define PSQ_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition seen");

`else

`define PSQ_ASSERT(label, clk, rst, prop)
`define PSQ_NEVER(label, clk, rst, expr)

`endif

`endif

FILE: hw/rtl/psq_pkg.sv
// types, codes and helpers of the sorted priority queue
package psq_pkg;

   localparam int QUEUE_DEPTH_DEF = 256;

   // command codes
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_POP    = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  cust_id;
      logic        cust_class;
      logic [15:0] arrival;
      logic [15:0] service;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        head_valid;
      logic [7:0]  head_id;
      logic        head_class;
      logic [15:0] head_arrival;
      logic [15:0] head_service;
      logic [8:0]  entry_total;
   } rsp_type;

   // stored entry, a smaller value is served earlier
   typedef struct packed {
      logic        class_n;
      logic [15:0] arrival;
      logic [15:0] service;
      logic [7:0]  id;
   } key_type;

   localparam int KEY_W = $bits(key_type);

   function automatic key_type make_key(input req_type r);
      key_type k;
      k.class_n = ~r.cust_class;
      k.arrival = r.arrival;
      k.service = r.service;
      k.id      = r.cust_id;
      return k;
   endfunction

endpackage

FILE: hw/rtl/psq_ram.sv
// generic single write port, single read port ram with registered read
module psq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/priority_sorted_queue_unit.sv
// top level of the sorted priority queue: sequencer, head register and tail memory
//
// request channel req_*: one word is one command, insert a request or pop the head.
// result channel rsp_*: exactly one word per command with status, head entry and
// the entry count after the command. csr_* writes the hold-head bit; the user must
// write it only while idle, the block does not enforce this. the head entry lives in
// a register; the remaining entries sit sorted in a circular buffer in one ram (one
// write, one registered read per cycle). an error, an insert into an empty queue or
// a pop of the last entry goes straight to the result; other pops first read the tail
// front. other inserts run a shift pass moving the larger tail entries up one slot
// each (0 .. count-1), one per cycle through the ram loop; with hold off and two or
// more entries the insert first reads the tail front to check the head, and a head
// held out of order gives two passes. one command is in flight at a time; req_stall
// is high from accept until the result is loaded into the output register, the next
// command is taken in the following cycle, so a new command waits for the last one and
// the ram shift pass sets the pace. the output register lets a new command be
// accepted while a result still waits. reset empties the queue by clearing the count;
// the ram is not cleared and no entry at or beyond the count is ever read. when
// rsp_stall is high a waiting result word holds; a finished command waits behind it.
`include "assert_macros.svh"

module priority_sorted_queue_unit #(
   parameter int QUEUE_DEPTH = psq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_stall,
   input  psq_pkg::req_type req_data,
   // result channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output psq_pkg::rsp_type rsp_data,
   // hold-head register write
   input  logic             csr_wr_en,
   input  logic             csr_wr_data
);

   localparam int ADDR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam logic [ADDR_W:0] DEPTH_EXT = (ADDR_W + 1)'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
   localparam logic [ADDR_W-1:0] OFF_ONE = ADDR_W'(1);

   typedef enum logic [2:0] {
      ST_IDLE,    // waiting for a command
      ST_POP_RD,  // tail front arriving from ram, becomes the head
      ST_FIX,     // tail front arriving, check the head is still in order
      ST_SETUP,   // start a shift pass for key_ff
      ST_RUN,     // shift pass, one tail entry per cycle
      ST_LAST,    // key lands in the front slot of the tail
      ST_DONE     // load the result word
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;     // head plus tail entries
   logic [ADDR_W-1:0] base_ff, base_in;      // physical slot of tail front
   logic [ADDR_W-1:0] idx_ff, idx_in;        // logical tail index being read
   logic             hold_ff, hold_in;
   logic             second_ff, second_in;   // another key waits for a pass
   logic             na_ff, na_in;           // pass key may displace the head
   logic [1:0]       status_ff, status_in;
   psq_pkg::key_type head_ff, head_in;
   psq_pkg::key_type key_ff, key_in;         // key of the current shift pass
   psq_pkg::key_type key2_ff, key2_in;
   logic             rsp_valid_ff, rsp_valid_in;
   psq_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // ram port
   logic                      ram_wr_en;
   logic [ADDR_W-1:0]         ram_wr_addr;
   logic [psq_pkg::KEY_W-1:0] ram_wr_data;
   logic                      ram_rd_en;
   logic [ADDR_W-1:0]         ram_rd_addr;
   logic [psq_pkg::KEY_W-1:0] ram_rd_data;
   psq_pkg::key_type          rd_key;

   psq_ram #(
      .WIDTH (psq_pkg::KEY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_tail_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_key = psq_pkg::key_type'(ram_rd_data);

   // tail slot address, wraps around the end of the ram
   function automatic logic [ADDR_W-1:0] slot_addr(input logic [ADDR_W-1:0] b,
                                                    input logic [ADDR_W-1:0] off);
      logic [ADDR_W:0] sum;
      sum = {1'b0, b} + {1'b0, off};
      if (sum >= DEPTH_EXT) begin
         sum = sum - DEPTH_EXT;
      end
      return sum[ADDR_W-1:0];
   endfunction

   psq_pkg::key_type new_key;
   psq_pkg::key_type pass_key;
   logic             swap_head;
   logic [ADDR_W-1:0] tail_size;
   logic             pass_done;

   assign new_key   = psq_pkg::make_key(req_data);
   assign swap_head = na_ff && (key_ff < head_ff);
   assign pass_key  = swap_head ? head_ff : key_ff;
   assign tail_size = ADDR_W'(count_ff - CNT_ONE);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      base_in      = base_ff;
      idx_in       = idx_ff;
      hold_in      = hold_ff;
      second_in    = second_ff;
      na_in        = na_ff;
      status_in    = status_ff;
      head_in      = head_ff;
      key_in       = key_ff;
      key2_in      = key2_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = base_ff;
      ram_wr_data  = key_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = base_ff;
      pass_done    = 1'b0;

      if (csr_wr_en) begin
         hold_in = csr_wr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               status_in = psq_pkg::STATUS_OK;
               second_in = 1'b0;
               key_in    = new_key;
               case (req_data.cmd)
                  psq_pkg::CMD_INSERT: begin
                     if (count_ff == CNT_FULL) begin
                        status_in = psq_pkg::STATUS_FULL;
                        state_in  = ST_DONE;
                     end else if (count_ff == '0) begin
                        head_in  = new_key;
                        count_in = CNT_ONE;
                        state_in = ST_DONE;
                     end else if (hold_ff || count_ff == CNT_ONE) begin
                        // held head stays put, else the new key may take its place
                        na_in    = ~hold_ff;
                        state_in = ST_SETUP;
                     end else begin
                        ram_rd_en = 1'b1;
                        state_in  = ST_FIX;
                     end
                  end
                  psq_pkg::CMD_POP: begin
                     if (count_ff == '0) begin
                        status_in = psq_pkg::STATUS_EMPTY;
                        state_in  = ST_DONE;
                     end else if (count_ff == CNT_ONE) begin
                        count_in = '0;
                        state_in = ST_DONE;
                     end else begin
                        ram_rd_en = 1'b1;
                        state_in  = ST_POP_RD;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_POP_RD: begin
            head_in  = rd_key;
            base_in  = slot_addr(base_ff, OFF_ONE);
            count_in = count_ff - CNT_ONE;
            state_in = ST_DONE;
         end

         ST_FIX: begin
            if (rd_key < head_ff) begin
               // head was left out of order while held: tail front takes over,
               // old head and new key each get a pass into the tail
               head_in   = rd_key;
               base_in   = slot_addr(base_ff, OFF_ONE);
               count_in  = count_ff - CNT_ONE;
               key_in    = head_ff;
               key2_in   = key_ff;
               second_in = 1'b1;
               na_in     = 1'b0;
            end else begin
               na_in = 1'b1;
            end
            state_in = ST_SETUP;
         end

         ST_SETUP: begin
            if (swap_head) begin
               head_in = key_ff;
            end
            key_in = pass_key;
            if (tail_size == '0) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = base_ff;
               ram_wr_data = pass_key;
               pass_done   = 1'b1;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = slot_addr(base_ff, tail_size - OFF_ONE);
               idx_in      = tail_size - OFF_ONE;
               state_in    = ST_RUN;
            end
         end

         ST_RUN: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = slot_addr(base_ff, idx_ff + OFF_ONE);
            if (rd_key > key_ff) begin
               // larger entry moves up one slot, keep walking down
               ram_wr_data = ram_rd_data;
               if (idx_ff == '0) begin
                  state_in = ST_LAST;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = slot_addr(base_ff, idx_ff - OFF_ONE);
                  idx_in      = idx_ff - OFF_ONE;
               end
            end else begin
               ram_wr_data = key_ff;
               pass_done   = 1'b1;
            end
         end

         ST_LAST: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = base_ff;
            ram_wr_data = key_ff;
            pass_done   = 1'b1;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.status       = status_ff;
               rsp_data_in.head_valid   = (count_ff != '0);
               rsp_data_in.head_id      = '0;
               rsp_data_in.head_class   = 1'b0;
               rsp_data_in.head_arrival = '0;
               rsp_data_in.head_service = '0;
               rsp_data_in.entry_total  = 9'(count_ff);
               if (count_ff != '0) begin
                  rsp_data_in.head_id      = head_ff.id;
                  rsp_data_in.head_class   = ~head_ff.class_n;
                  rsp_data_in.head_arrival = head_ff.arrival;
                  rsp_data_in.head_service = head_ff.service;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a finished pass adds one entry, then runs the waiting key if any
      if (pass_done) begin
         count_in = count_ff + CNT_ONE;
         if (second_ff) begin
            key_in    = key2_ff;
            second_in = 1'b0;
            na_in     = 1'b1;
            state_in  = ST_SETUP;
         end else begin
            state_in = ST_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         base_ff      <= '0;
         hold_ff      <= 1'b0;
         second_ff    <= 1'b0;
         na_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         base_ff      <= base_in;
         hold_ff      <= hold_in;
         second_ff    <= second_in;
         na_ff        <= na_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      status_ff   <= status_in;
      head_ff     <= head_in;
      key_ff      <= key_in;
      key2_ff     <= key2_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `PSQ_NEVER(a_count_range, clock, reset, count_ff > CNT_FULL)
   `PSQ_ASSERT(a_busy_after_accept, clock, reset,
      req_valid && !req_stall |=> state_ff != ST_IDLE)
   `PSQ_NEVER(a_ram_same_slot, clock, reset,
      ram_wr_en && ram_rd_en && (ram_wr_addr == ram_rd_addr))
   `PSQ_NEVER(a_read_only_filled, clock, reset,
      ram_rd_en && (count_ff < CNT_W'(2)))

endmodule

FILE: dv/priority_sorted_queue_unit_tb.sv
// self-checking testbench of the sorted priority queue: directed rows, random phases, field checks
module priority_sorted_queue_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = psq_pkg::QUEUE_DEPTH_DEF;
   localparam int ITEM_GOAL   = 1500;   // words sent before the run winds down
   localparam int CALM_TAIL   = 150;    // last words go without any idling
   localparam int QUIET_LIMIT = 4000;   // two full shift passes plus stalls, several times over
   localparam int PLAN_ROWS   = 27;

   // service rank: a smaller value goes out first
   // {inverted class, arrival, service, id}
   typedef logic [40:0] rank_type;

   typedef enum bit {ROW_WORD, ROW_HOLD} row_kind_type;

   typedef struct {
      row_kind_type     kind;
      bit               hold;      // value written on a hold row
      psq_pkg::req_type word;
      bit               typed;     // use the typed-in result instead of the prediction
      psq_pkg::rsp_type want;
   } plan_row_type;

   localparam psq_pkg::req_type POP_ZERO =
      {psq_pkg::CMD_POP, 8'h00, 1'b0, 16'h0000, 16'h0000};
   localparam psq_pkg::req_type POP_ONES =
      {psq_pkg::CMD_POP, 8'hff, 1'b1, 16'hffff, 16'hffff};
   localparam psq_pkg::rsp_type EMPTY_RESULT =
      {psq_pkg::STATUS_EMPTY, 1'b0, 8'h00, 1'b0, 16'h0000, 16'h0000, 9'd0};

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_stall;
   psq_pkg::req_type req_data    = '0;
   logic             rsp_valid;
   logic             rsp_stall   = 1'b0;
   psq_pkg::rsp_type rsp_data;
   logic             csr_wr_en   = 1'b0;
   logic             csr_wr_data = 1'b0;

   // predictor state: sorted waiting requests and the hold-head bit
   rank_type waiting_keys[$];
   bit       hold_model = 1'b0;

   // results owed by the block, oldest first
   psq_pkg::rsp_type due_results[$];

   bit      calm = 1'b0;       // no idling on either side
   int      stall_run = 0;
   int      quiet_cycles = 0;

   int      mismatches = 0;
   int      sent_words = 0;
   int      results_checked = 0;
   int      inserts_seen = 0;
   int      pops_seen = 0;
   int      full_drops = 0;
   int      empty_pops = 0;
   int      peak_depth = 0;
   int      hold_writes = 0;

   // directed rows: extremes, tie breakers, held head, empty and error cases
   plan_row_type plan [PLAN_ROWS] = '{
      '{ROW_HOLD, 1'b0, '0, 1'b0, '0},
      // pop on an empty queue right after reset
      '{ROW_WORD, 1'b0, POP_ZERO, 1'b1, EMPTY_RESULT},
      // all-ones request becomes the head
      '{ROW_WORD, 1'b0, {psq_pkg::CMD_INSERT, 8'hff, 1'b1, 16'hffff, 16'hffff}, 1'b1,
        {psq_pkg::STATUS_OK, 1'b1, 8'hff, 1'b1, 16'hffff, 16'hffff, 9'd1}},
      // all-zero request is normal class, so it lines up behind
      '{ROW_WORD, 1'b0, {psq_pkg::CMD_INSERT, 8'h00, 1'b0, 16'h0000, 16'h0000}, 1'b1,
        {psq_pkg::STATUS_OK, 1'b1, 8'hff, 1'b1, 16'hffff, 16'hffff, 9'd2}},
      // earlier arrival wins within the class
      '{ROW_WORD, 1'b0, {psq_pkg::CMD_INSERT, 8'h80, 1'b1, 16'h0000, 16'hffff}, 1'b1,
        {psq_pkg::STATUS_OK, 1'b1, 8'h80, 1'b1, 16'h0000, 16'hffff, 9'd3}},
      // shorter service wins on equal arrival
      '{ROW_WORD, 1'b0, {psq_pkg::CMD_INSERT, 8'h55, 1'b1, 16'h0000, 16'h0000}, 1'b1,
        {psq_pkg::STATUS_OK, 1'b1, 8'h55, 1'b1, 16'h0000, 16'h0000, 9'd4}},
      // smaller id breaks the last tie
      '{ROW_WORD, 1'b0, {psq_pkg::CMD_INSERT, 8'h54, 1'b1, 16'h0000, 16'h0000}, 1'b1,
        {psq_pkg::STATUS_OK, 1'b1, 8'h54, 1'b1, 16'h0000, 16'h0000, 9'd5}},
      // identical request goes behind its twin
      '{ROW_WORD, 1'b0, {psq_pkg::CMD_INSERT, 8'h54, 1'b1, 16'h0000, 16'h0000}, 1'b0, '0},
      '{ROW_WORD, 1'b0, {psq_pkg::CMD_INSERT, 8'haa, 1'b0, 16'haaaa, 16'h5555}, 1'b0, '0},
      '{ROW_WORD, 1'b0, {psq_pkg::CMD_INSERT, 8'h55, 1'b0, 16'h5555, 16'haaaa}, 1'b0, '0},
      '{ROW_WORD, 1'b0, POP_ONES, 1'b0, '0},
      '{ROW_WORD, 1'b0, POP_ZERO, 1'b0, '0},
      '{ROW_WORD, 1'b0, POP_ONES, 1'b0, '0},
      // held head stays in front of a better newcomer
      '{ROW_HOLD, 1'b1, '0, 1'b0, '0},
      '{ROW_WORD, 1'b0, {psq_pkg::CMD_INSERT, 8'h01, 1'b1, 16'h0000, 16'h0000}, 1'b0, '0},
      // served head leaves while held
      '{ROW_WORD, 1'b0, POP_ZERO, 1'b0, '0},
      '{ROW_WORD, 1'b0, {psq_pkg::CMD_INSERT, 8'h00, 1'b1, 16'h0000, 16'h0000}, 1'b0, '0},
      // hold released: next insert moves the stale head to its place
      '{ROW_HOLD, 1'b0, '0, 1'b0, '0},
      '{ROW_WORD, 1'b0, {psq_pkg::CMD_INSERT, 8'h02, 1'b0, 16'hffff, 16'h0000}, 1'b0, '0},
      '{ROW_WORD, 1'b0, POP_ONES, 1'b0, '0},
      '{ROW_WORD, 1'b0, POP_ZERO, 1'b0, '0},
      '{ROW_WORD, 1'b0, POP_ONES, 1'b0, '0},
      '{ROW_WORD, 1'b0, POP_ZERO, 1'b0, '0},
      '{ROW_WORD, 1'b0, POP_ONES, 1'b0, '0},
      '{ROW_WORD, 1'b0, POP_ZERO, 1'b0, '0},
      '{ROW_WORD, 1'b0, POP_ONES, 1'b0, '0},
      // drained again, pop must flag empty
      '{ROW_WORD, 1'b0, POP_ONES, 1'b1, EMPTY_RESULT}
   };

   priority_sorted_queue_unit #(
      .QUEUE_DEPTH(DEPTH)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   // predicted effect of one accepted command on the queue, and the word it returns
   function automatic psq_pkg::rsp_type apply_command(input psq_pkg::req_type w);
      psq_pkg::rsp_type r;
      rank_type         k;
      int               first;
      int               i;
      int               j;
      r = '0;
      r.status = psq_pkg::STATUS_OK;
      if (w.cmd == psq_pkg::CMD_INSERT) begin
         inserts_seen++;
         if (waiting_keys.size() >= DEPTH) begin
            r.status = psq_pkg::STATUS_FULL;
            full_drops++;
         end else begin
            waiting_keys.push_back({~w.cust_class, w.arrival, w.service, w.cust_id});
            // a held head is left where it is, the rest is re-sorted
            first = (hold_model && waiting_keys.size() > 1) ? 1 : 0;
            for (i = first + 1; i < waiting_keys.size(); i++) begin
               k = waiting_keys[i];
               j = i;
               // strict compare keeps a newer equal request behind the older one
               while (j > first && waiting_keys[j - 1] > k) begin
                  waiting_keys[j] = waiting_keys[j - 1];
                  j--;
               end
               waiting_keys[j] = k;
            end
            if (waiting_keys.size() > peak_depth) peak_depth = waiting_keys.size();
         end
      end else begin
         pops_seen++;
         if (waiting_keys.size() == 0) begin
            r.status = psq_pkg::STATUS_EMPTY;
            empty_pops++;
         end else begin
            void'(waiting_keys.pop_front());
         end
      end
      // head fields read as zero on an empty queue
      if (waiting_keys.size() > 0) begin
         k = waiting_keys[0];
         r.head_valid   = 1'b1;
         r.head_id      = k[7:0];
         r.head_class   = ~k[40];
         r.head_arrival = k[39:24];
         r.head_service = k[23:8];
      end
      r.entry_total = 9'(waiting_keys.size());
      return r;
   endfunction

   // arrival and service: extremes, a tight range for ties, or anything
   function automatic logic [15:0] pick_ticks();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hffff;
         2, 3:    return 16'($urandom_range(0, 3));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic psq_pkg::req_type random_word(input logic cmd);
      psq_pkg::req_type w;
      w.cmd        = cmd;
      w.cust_id    = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
      w.cust_class = 1'($urandom_range(0, 1));
      w.arrival    = pick_ticks();
      w.service    = pick_ticks();
      return w;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 40)
         $display("mismatch at %0t ns, result %0d: %s", $time, results_checked, what);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
   endtask

   // called at a falling edge, returns at a falling edge after the word is taken
   task automatic send_word(input psq_pkg::req_type w, input bit typed,
                            input psq_pkg::rsp_type want);
      psq_pkg::rsp_type predicted;
      // sender gap burst
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_data  <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = apply_command(w);
      due_results.push_back(typed ? want : predicted);
      sent_words++;
      @(negedge clock);
   endtask

   // hold off the sender until every owed result has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (due_results.size() != 0) @(negedge clock);
   endtask

   // hold-head is only written with nothing in flight
   task automatic set_hold(input bit value);
      drain();
      repeat (4) @(negedge clock);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      hold_model = value;
      hold_writes++;
   endtask

   // receiver stall: random bursts of stall between stall-free stretches
   always @(negedge clock) begin
      if (calm) begin
         rsp_stall <= 1'b0;
         stall_run <= 0;
      end else if (stall_run == 0) begin
         if ($urandom_range(0, 9) < 3) begin
            rsp_stall <= 1'b1;
            stall_run <= $urandom_range(1, 8) - 1;
         end else begin
            rsp_stall <= 1'b0;
            stall_run <= $urandom_range(1, 20) - 1;
         end
      end else begin
         stall_run <= stall_run - 1;
      end
   end

   // result checker: every taken word against the oldest expectation
   always @(posedge clock) begin : result_check
      psq_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            report_mismatch("result word with no command waiting");
         end else begin
            want = due_results.pop_front();
            check_field("status", 32'(rsp_data.status), 32'(want.status));
            check_field("head_valid", 32'(rsp_data.head_valid), 32'(want.head_valid));
            check_field("head_id", 32'(rsp_data.head_id), 32'(want.head_id));
            check_field("head_class", 32'(rsp_data.head_class), 32'(want.head_class));
            check_field("head_arrival", 32'(rsp_data.head_arrival), 32'(want.head_arrival));
            check_field("head_service", 32'(rsp_data.head_service), 32'(want.head_service));
            check_field("entry_total", 32'(rsp_data.entry_total), 32'(want.entry_total));
         end
         results_checked++;
      end
   end

   // watchdog: too long without any handshake ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results owed",
                     quiet_cycles, due_results.size());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int    phase;
      int    burst;
      int    target;
      bit    hold_pick;
      logic  cmd;

      // synchronous reset, released at a falling edge
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed rows
      foreach (plan[r]) begin
         if (plan[r].kind == ROW_HOLD)
            set_hold(plan[r].hold);
         else
            send_word(plan[r].word, plan[r].typed, plan[r].want);
      end

      // random phases; the queue carries over, so a head held out of order
      // in one phase meets an unheld insert in a later one
      phase = 0;
      while (sent_words < ITEM_GOAL) begin
         if (sent_words >= ITEM_GOAL - CALM_TAIL) calm = 1'b1;
         case (phase)
            0:       hold_pick = 1'b1;
            1:       hold_pick = 1'b0;
            default: hold_pick = 1'($urandom_range(0, 1));
         endcase
         set_hold(hold_pick);

         if (phase == 2) begin
            // fill to the brim, knock on the full queue, then empty it out and pop the empty queue
            while (waiting_keys.size() < DEPTH)
               send_word(random_word(psq_pkg::CMD_INSERT), 1'b0, '0);
            repeat (4) send_word(random_word(psq_pkg::CMD_INSERT), 1'b0, '0);
            while (waiting_keys.size() > 0)
               send_word(random_word(psq_pkg::CMD_POP), 1'b0, '0);
            repeat (3) send_word(random_word(psq_pkg::CMD_POP), 1'b0, '0);
         end else begin
            // mixed traffic steered toward a small occupancy, sometimes a larger one
            burst  = $urandom_range(60, 120);
            target = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 8);
            repeat (burst) begin
               if (waiting_keys.size() < target)
                  cmd = ($urandom_range(0, 3) != 0) ? psq_pkg::CMD_INSERT : psq_pkg::CMD_POP;
               else
                  cmd = ($urandom_range(0, 3) != 0) ? psq_pkg::CMD_POP : psq_pkg::CMD_INSERT;
               send_word(random_word(cmd), 1'b0, '0);
               // occasional full drain in the middle of traffic
               if (!calm && $urandom_range(0, 59) == 0) drain();
            end
         end
         phase++;
      end

      // let the last results come home, then a short quiet tail
      drain();
      repeat (20) @(negedge clock);

      $display("run: %0d commands (%0d inserts, %0d pops), %0d results checked, %0d phases",
               sent_words, inserts_seen, pops_seen, results_checked, phase);
      $display("run: %0d full drops, %0d empty pops, peak depth %0d, %0d hold-head writes",
               full_drops, empty_pops, peak_depth, hold_writes);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/psq_pkg.sv
hw/rtl/psq_ram.sv
hw/rtl/priority_sorted_queue_unit.sv
dv/priority_sorted_queue_unit_tb.sv
